// File: rtl/audio_level_meter_assert.svh
// Assertion macros used by the checker file.
`ifndef AUDIO_LEVEL_METER_ASSERT_SVH
`define AUDIO_LEVEL_METER_ASSERT_SVH

// Same-cycle implication.
`define ALM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// Types, constants and arithmetic helpers of the audio level meter.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int BLOCK_MAX_DEF = 4096;
  localparam int SAMPLE_W      = 24;
  localparam int MAG_W         = SAMPLE_W - 1;
  localparam int LOG_IN_W      = 64;
  localparam int LOG_N_W       = 6;
  localparam int LOG_W         = LOG_N_W + 16;
  localparam int LDIFF_W       = 26;
  localparam int DB_P_W        = 46;
  localparam int SM_P_W        = 34;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 16;

  localparam logic signed [15:0] SILENCE_RESET = -16'sd25600;
  localparam logic signed [19:0] K20 = 20'sd394566;
  localparam logic signed [19:0] K10 = 20'sd197283;

  typedef enum logic [CFG_AW-1:0] {
    REG_ACTIVE, REG_SILENCE, REG_CLIP, REG_ATTACK, REG_RELEASE, REG_HOLD, REG_DECAY
  } cfg_reg_t;

  typedef enum logic [1:0] {LSEL_PEAK, LSEL_SUM, LSEL_CNT} log_sel_t;

  typedef enum logic [1:0] {LOG_IDLE, LOG_NORM, LOG_SQ, LOG_DONE} log_state_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_DATA, ST_ACC, ST_LOG_START, ST_LOG_WAIT,
    ST_DB_MUL, ST_DB_FIN, ST_T_MUL, ST_T_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic                       kind;
    logic [2:0]                 channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_block;
  } in_t;

  typedef struct packed {
    logic               report;
    logic [2:0]         channel_res;
    logic signed [15:0] level_db;
    logic signed [15:0] rms_db;
    logic signed [15:0] hold_db;
    logic               clipping;
    logic               clip_event;
    logic               last;
  } out_t;

  // round half away from zero of p / 2^24, saturate, floor at sil
  function automatic logic signed [15:0] to_db(input logic signed [DB_P_W-1:0] p,
                                               input logic signed [15:0] sil);
    logic [DB_P_W-1:0]        mag;
    logic [DB_P_W-1:0]        q;
    logic signed [DB_P_W-1:0] r;
    mag = p[DB_P_W-1] ? DB_P_W'(-p) : DB_P_W'(p);
    q = (mag + (DB_P_W'(1) << 23)) >> 24;
    r = p[DB_P_W-1] ? -$signed(q) : $signed(q);
    if (r < -46'sd32768) r = -46'sd32768;
    else if (r > 46'sd32767) r = 46'sd32767;
    if (r < DB_P_W'(sil)) r = DB_P_W'(sil);
    return r[15:0];
  endfunction

  // round half away from zero of p / 2^16
  function automatic logic signed [17:0] smooth_round(input logic signed [SM_P_W-1:0] p);
    logic [SM_P_W-1:0] m;
    logic [SM_P_W-1:0] q;
    m = p[SM_P_W-1] ? SM_P_W'(-p) : SM_P_W'(p);
    q = (m + SM_P_W'(32768)) >> 16;
    return p[SM_P_W-1] ? -$signed(18'(q)) : $signed(18'(q));
  endfunction

endpackage

// File: rtl/alm_ram.sv
// ----------------------------------------------------------------------------
// alm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/alm_log2.sv
// ----------------------------------------------------------------------------
// alm_log2
// Multi-cycle log2 in Q.16: normalize, then 16 squarings of the mantissa.
// ----------------------------------------------------------------------------
module alm_log2 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [alm_pkg::LOG_IN_W-1:0] x,
  output logic                         done,
  output logic [alm_pkg::LOG_W-1:0]    result
);
  import alm_pkg::*;

  log_state_t           state, state_next;
  logic [LOG_IN_W-1:0]  xr;
  logic [LOG_N_W-1:0]   n;
  logic [31:0]          y;
  logic [15:0]          frac;
  logic [3:0]           k;
  logic [63:0]          prod;
  logic [32:0]          t;

  assign prod = 64'(y) * 64'(y);
  assign t    = prod[63:31];

  always_comb begin
    state_next = state;
    case (state)
      LOG_IDLE: if (start) state_next = LOG_NORM;
      LOG_NORM: if (xr[LOG_IN_W-1]) state_next = LOG_SQ;
      LOG_SQ:   if (k == 4'd15) state_next = LOG_DONE;
      LOG_DONE: state_next = LOG_IDLE;
      default:  state_next = LOG_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == LOG_DONE);
    result = {n, frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LOG_IDLE: begin
        if (start) begin
          xr <= x;
          n  <= LOG_N_W'(LOG_IN_W - 1);
        end
      end
      LOG_NORM: begin
        if (xr[LOG_IN_W-1]) begin
          y    <= xr[LOG_IN_W-1 -: 32];
          frac <= '0;
          k    <= '0;
        end else if (xr[LOG_IN_W-1 -: 8] == '0) begin
          xr <= xr << 8;
          n  <= n - LOG_N_W'(8);
        end else begin
          xr <= xr << 1;
          n  <= n - LOG_N_W'(1);
        end
      end
      LOG_SQ: begin
        if (t[32]) begin
          y    <= t[32:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          y    <= t[31:0];
          frac <= {frac[14:0], 1'b0};
        end
        k <= k + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/audio_level_meter.sv
// ----------------------------------------------------------------------------
// audio_level_meter
// Multichannel peak / RMS meter with peak hold, smoothing and clip detect.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; per-channel state sits in one RAM
// (read, modify, write back). A sample that does not end a block is read,
// accumulated and written back. A block end runs up to three log2
// conversions on the shared log2 unit (skipped for a zero input), each a
// normalize phase plus 16 squarings. A tick reads, smooths and writes back
// each active channel in turn. Block ends and ticks wait while the output
// stalls; a result waiting in the output register does not block the next
// input transaction. The state RAM needs no clearing pass after reset.
module audio_level_meter #(
  parameter int CHANNELS  = alm_pkg::CHANNELS_DEF,
  parameter int BLOCK_MAX = alm_pkg::BLOCK_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  alm_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output alm_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [alm_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [alm_pkg::CFG_DW-1:0] cfg_data
);
  import alm_pkg::*;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(BLOCK_MAX + 1);
  localparam int SUM_FULL = 2 * MAG_W + CNT_W;
  localparam int SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
  localparam int SUM_X    = SUM_W + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int ACT_W    = $clog2(CHANNELS + 16);

  typedef struct packed {
    logic [MAG_W-1:0]   peak;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
    logic signed [15:0] lnow;
    logic signed [15:0] rnow;
    logic signed [15:0] lsm;
    logic signed [15:0] rsm;
    logic signed [15:0] hold;
    logic [15:0]        tsp;
    logic               clip;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam entry_t RESET_ENTRY = '{peak: '0, sum: '0, cnt: '0,
                                     lnow: SILENCE_RESET, rnow: SILENCE_RESET,
                                     lsm: SILENCE_RESET, rsm: SILENCE_RESET,
                                     hold: SILENCE_RESET, tsp: '0, clip: 1'b0};

  // configuration
  logic [3:0]         active_channels;
  logic signed [15:0] silence_level;
  logic signed [15:0] clip_level;
  logic [15:0]        attack_coeff;
  logic [15:0]        release_coeff;
  logic [15:0]        hold_ticks;
  logic [14:0]        decay_step;

  state_t                    state, state_next;
  log_sel_t                  log_sel;
  logic [CHANNELS-1:0]       vld;
  logic [CH_W-1:0]           cur;
  logic                      kind_r;
  logic                      last_r;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          mag_in;
  logic [SQ_W-1:0]           sq;
  entry_t                    e, e_acc, e_fin, e_tick, rd_entry;
  logic [SUM_X-1:0]          sum_add;
  logic [LOG_W-1:0]          lp, ls, lc;
  logic signed [LDIFF_W-1:0] ldp, ldr;
  logic signed [DB_P_W-1:0]  pp, pr;
  logic signed [SM_P_W-1:0]  spl, spr;
  logic signed [16:0]        dl, dr;
  logic signed [16:0]        cl, cr;
  logic signed [15:0]        pk, rm;
  logic [15:0]               tsp_inc;
  logic signed [16:0]        hdec;
  out_t                      res, res_blk, res_tick;
  logic [ACT_W-1:0]          n_act;
  logic                      accept, sample_ok, tick_last, out_free;
  logic                      ram_we, ram_re, log_start, log_done, out_load;
  logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;
  logic [LOG_IN_W-1:0]       log_x;
  logic [LOG_W-1:0]          log_res;

  alm_ram #(.WIDTH(ENTRY_W), .DEPTH(CHANNELS), .AW(CH_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  alm_log2 u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  always_comb begin
    if (active_channels == 4'd0) n_act = ACT_W'(1);
    else if (ACT_W'(active_channels) > ACT_W'(CHANNELS)) n_act = ACT_W'(CHANNELS);
    else n_act = ACT_W'(active_channels);
  end

  assign sample_ok = ACT_W'(in_data.channel) < n_act;
  assign accept    = in_valid && in_ready;
  assign tick_last = (ACT_W'(cur) == n_act - ACT_W'(1));
  assign out_free  = !out_valid || out_ready;
  assign rd_entry  = vld[cur] ? entry_t'(ram_rdata) : RESET_ENTRY;

  always_comb begin
    if (in_data.sample == {1'b1, {MAG_W{1'b0}}}) mag_in = '1;
    else if (in_data.sample[SAMPLE_W-1]) mag_in = MAG_W'(-in_data.sample);
    else mag_in = MAG_W'(in_data.sample);
  end

  // accumulate one sample (ignored once the count reaches BLOCK_MAX)
  always_comb begin
    e_acc   = e;
    sum_add = SUM_X'(e.sum) + SUM_X'(sq);
    if (e.cnt < CNT_W'(BLOCK_MAX)) begin
      if (mag > e.peak) e_acc.peak = mag;
      e_acc.sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      e_acc.cnt = e.cnt + CNT_W'(1);
    end
  end

  always_comb begin
    case (log_sel)
      LSEL_PEAK: log_x = LOG_IN_W'(e.peak);
      LSEL_SUM:  log_x = LOG_IN_W'(e.sum);
      LSEL_CNT:  log_x = LOG_IN_W'(e.cnt);
      default:   log_x = '0;
    endcase
  end

  assign ldp = $signed(LDIFF_W'(lp)) - $signed(LDIFF_W'(MAG_W * 65536));
  assign ldr = $signed(LDIFF_W'(ls)) - $signed(LDIFF_W'(lc))
             - $signed(LDIFF_W'(2 * MAG_W * 65536));

  // block end
  always_comb begin
    pk = (e.peak == '0) ? silence_level : to_db(pp, silence_level);
    rm = (e.sum == '0 || e.cnt == '0) ? silence_level : to_db(pr, silence_level);
    e_fin      = e;
    e_fin.lnow = pk;
    e_fin.rnow = rm;
    e_fin.clip = (pk > clip_level);
    e_fin.peak = '0;
    e_fin.sum  = '0;
    e_fin.cnt  = '0;
    if (pk > e.hold) begin
      e_fin.hold = pk;
      e_fin.tsp  = '0;
    end
    res_blk.report      = 1'b0;
    res_blk.channel_res = 3'(cur);
    res_blk.level_db    = pk;
    res_blk.rms_db      = rm;
    res_blk.hold_db     = e_fin.hold;
    res_blk.clipping    = e_fin.clip;
    res_blk.clip_event  = (pk > clip_level) && !e.clip;
    res_blk.last        = 1'b1;
  end

  // tick smoothing and hold ageing
  assign dl = 17'(e.lnow) - 17'(e.lsm);
  assign dr = 17'(e.rnow) - 17'(e.rsm);
  assign cl = $signed({1'b0, (e.lnow > e.lsm) ? attack_coeff : release_coeff});
  assign cr = $signed({1'b0, (e.rnow > e.rsm) ? attack_coeff : release_coeff});
  assign tsp_inc = (e.tsp == 16'hFFFF) ? e.tsp : e.tsp + 16'd1;
  assign hdec = 17'(e.hold) - $signed({2'b00, decay_step});

  always_comb begin
    e_tick     = e;
    e_tick.lsm = 16'(18'(e.lsm) + smooth_round(spl));
    e_tick.rsm = 16'(18'(e.rsm) + smooth_round(spr));
    if (e.lnow > e.hold) begin
      e_tick.hold = e.lnow;
      e_tick.tsp  = '0;
    end else begin
      e_tick.tsp = tsp_inc;
      if (tsp_inc > hold_ticks) e_tick.hold = (hdec > 17'(e.lnow)) ? hdec[15:0] : e.lnow;
    end
    res_tick.report      = 1'b1;
    res_tick.channel_res = 3'(cur);
    res_tick.level_db    = e_tick.lsm;
    res_tick.rms_db      = e_tick.rsm;
    res_tick.hold_db     = e_tick.hold;
    res_tick.clipping    = e.clip;
    res_tick.clip_event  = 1'b0;
    res_tick.last        = tick_last;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept && (in_data.kind || sample_ok)) state_next = ST_RD;
      ST_RD:        state_next = ST_DATA;
      ST_DATA:      state_next = kind_r ? ST_T_MUL : ST_ACC;
      ST_ACC:       state_next = last_r ? ST_LOG_START : ST_IDLE;
      ST_LOG_START: begin
        if (log_x != '0) state_next = ST_LOG_WAIT;
        else if (log_sel == LSEL_CNT) state_next = ST_DB_MUL;
      end
      ST_LOG_WAIT: begin
        if (log_done) state_next = (log_sel == LSEL_CNT) ? ST_DB_MUL : ST_LOG_START;
      end
      ST_DB_MUL:    state_next = ST_DB_FIN;
      ST_DB_FIN:    state_next = ST_OUT;
      ST_T_MUL:     state_next = ST_T_FIN;
      ST_T_FIN:     state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = (kind_r && !tick_last) ? ST_RD : ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    ram_re    = (state == ST_RD);
    ram_we    = (state == ST_ACC && !last_r) || (state == ST_OUT && out_free);
    ram_wdata = (state == ST_ACC) ? ENTRY_W'(e_acc) : ENTRY_W'(e);
    log_start = (state == ST_LOG_START) && (log_x != '0);
    out_load  = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      log_sel         <= LSEL_PEAK;
      vld             <= '0;
      out_valid       <= 1'b0;
      active_channels <= 4'd2;
      silence_level   <= SILENCE_RESET;
      clip_level      <= 16'sd0;
      attack_coeff    <= 16'd65535;
      release_coeff   <= 16'd7000;
      hold_ticks      <= 16'd45;
      decay_step      <= 15'd170;
    end else begin
      state <= state_next;
      if (ram_we) vld[cur] <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == ST_ACC) log_sel <= LSEL_PEAK;
      else if ((state == ST_LOG_START && log_x == '0) || (state == ST_LOG_WAIT && log_done)) begin
        case (log_sel)
          LSEL_PEAK: log_sel <= LSEL_SUM;
          LSEL_SUM:  log_sel <= LSEL_CNT;
          default:   log_sel <= LSEL_PEAK;
        endcase
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_ACTIVE:  active_channels <= cfg_data[3:0];
          REG_SILENCE: silence_level   <= $signed(cfg_data);
          REG_CLIP:    clip_level      <= $signed(cfg_data);
          REG_ATTACK:  attack_coeff    <= cfg_data;
          REG_RELEASE: release_coeff   <= cfg_data;
          REG_HOLD:    hold_ticks      <= cfg_data;
          REG_DECAY:   decay_step      <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          kind_r <= in_data.kind;
          last_r <= in_data.last_in_block;
          cur    <= in_data.kind ? '0 : CH_W'(in_data.channel);
          mag    <= mag_in;
        end
      end
      ST_DATA: begin
        e  <= rd_entry;
        sq <= SQ_W'(mag) * SQ_W'(mag);
      end
      ST_ACC:      e <= e_acc;
      ST_LOG_WAIT: begin
        if (log_done) begin
          case (log_sel)
            LSEL_PEAK: lp <= log_res;
            LSEL_SUM:  ls <= log_res;
            default:   lc <= log_res;
          endcase
        end
      end
      ST_DB_MUL: begin
        pp <= DB_P_W'(ldp) * DB_P_W'(K20);
        pr <= DB_P_W'(ldr) * DB_P_W'(K10);
      end
      ST_DB_FIN: begin
        e   <= e_fin;
        res <= res_blk;
      end
      ST_T_MUL: begin
        spl <= SM_P_W'(dl) * SM_P_W'(cl);
        spr <= SM_P_W'(dr) * SM_P_W'(cr);
      end
      ST_T_FIN: begin
        e   <= e_tick;
        res <= res_tick;
      end
      ST_OUT: begin
        if (out_free && kind_r) cur <= cur + CH_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/alm_checker.sv
// ----------------------------------------------------------------------------
// alm_checker
// Port-level checks of the audio level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_level_meter_assert.svh"

module alm_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input alm_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input alm_pkg::out_t out_data
);
  import alm_pkg::*;

  `ALM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output dropped")
  `ALM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data),
                   "output payload changed while stalled")
  `ALM_ASSERT_NEXT(a_tick_busy, clk, rst, in_valid && in_ready && in_data.kind, !in_ready,
                   "tick did not start a channel walk")
  `ALM_ASSERT_NOW(a_block_last, clk, rst, out_valid && !out_data.report, out_data.last,
                  "block-end result without last")
  `ALM_ASSERT_NOW(a_clip_event, clk, rst, out_valid && out_data.clip_event,
                  out_data.clipping && !out_data.report, "clip event without clipping")

endmodule

bind audio_level_meter alm_checker u_alm_checker (.*);
